FILE: rtl/kdms_pkg.sv
// ----------------------------------------------------------------------------
// kdms_pkg
// Shared types and constants for the k-th distinct smallest and largest
// selector: field widths, the controller states and the command bundle.
// ----------------------------------------------------------------------------
package kdms_pkg;

   // Width of one data value and of the rank register.
   localparam int VALUE_W = 32;
   localparam int RANK_W  = 5;

   // Default depth of each sorted list (deepest rank the lists can report).
   localparam int MAX_RANK_DEF = 16;

   // Value of the rank register after reset.
   localparam logic [RANK_W-1:0] RANK_RESET = 5'd1;

   // Controller states.
   typedef enum logic [0:0] {
      ST_RUN,
      ST_PICK
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic insert;   // take the present item's value into both lists
      logic load;     // capture the selected ranks into the result register
      logic clear;    // empty both lists for the next data set
   } cmd_type;

endpackage

FILE: rtl/kdms_list.sv
// ----------------------------------------------------------------------------
// kdms_list
// One sorted list of distinct values held in a row of compare-insert cells.
// Every cell compares the new value with its entry in parallel; the list
// shifts below the insertion point at once. Descending order keeps the
// largest values, ascending order the smallest.
// ----------------------------------------------------------------------------
module kdms_list
   import kdms_pkg::*;
#(
   parameter int MAX_RANK = MAX_RANK_DEF,
   parameter bit DESCEND  = 1'b1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       insert,
   input  logic                       clear,
   input  logic signed [VALUE_W-1:0]  value,
   input  logic [RANK_W-1:0]          rank_k,
   output logic signed [VALUE_W-1:0]  kth_value,
   output logic                       found
);

   localparam int FW    = $clog2(MAX_RANK + 1);
   localparam int CW    = $clog2(MAX_RANK + 2);
   localparam int SEL_W = (CW > RANK_W) ? CW : RANK_W;

   logic signed [VALUE_W-1:0] list_ff [MAX_RANK];
   logic signed [VALUE_W-1:0] list_in [MAX_RANK];
   logic [FW-1:0]             fill_ff;
   logic [FW-1:0]             fill_in;

   logic [MAX_RANK-1:0]       ahead;
   logic [MAX_RANK-1:0]       same;
   logic                      grow;
   logic [SEL_W-1:0]          k_ext;
   logic [SEL_W-1:0]          fill_ext;

   // Per-cell compare: an entry stays ahead of the new value when it is
   // valid and ranks before it; a valid equal entry blocks the insertion.
   always_comb begin
      for (int i = 0; i < MAX_RANK; i++) begin
         if (DESCEND) begin
            ahead[i] = (FW'(i) < fill_ff) && (list_ff[i] > value);
         end else begin
            ahead[i] = (FW'(i) < fill_ff) && (list_ff[i] < value);
         end
         same[i] = (FW'(i) < fill_ff) && (list_ff[i] == value);
      end
   end

   // Shift network: cells ahead hold, the first other cell takes the new
   // value and the rest move one place down.
   always_comb begin
      if (ahead[0]) begin
         list_in[0] = list_ff[0];
      end else begin
         list_in[0] = value;
      end
      for (int i = 1; i < MAX_RANK; i++) begin
         if (ahead[i]) begin
            list_in[i] = list_ff[i];
         end else if (ahead[i-1]) begin
            list_in[i] = value;
         end else begin
            list_in[i] = list_ff[i-1];
         end
      end
   end

   // The fill count grows when a new distinct value lands in a list that
   // still has room; a value behind every entry of a full list is dropped.
   always_comb begin
      grow    = insert && !(|same) && (fill_ff != FW'(MAX_RANK));
      fill_in = fill_ff;
      if (clear) begin
         fill_in = '0;
      end else if (grow) begin
         fill_in = fill_ff + FW'(1);
      end
   end

   // Fill count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Entry registers: written only when a distinct value goes in.
   always_ff @(posedge clock) begin
      if (insert && !(|same) && !ahead[MAX_RANK-1]) begin
         list_ff <= list_in;
      end
   end

   // Rank selection: the k-th entry if the rank is held, otherwise zero.
   always_comb begin
      k_ext     = SEL_W'(rank_k);
      fill_ext  = SEL_W'(fill_ff);
      found     = (k_ext != '0) && (k_ext <= SEL_W'(MAX_RANK)) && (k_ext <= fill_ext);
      kth_value = '0;
      for (int i = 0; i < MAX_RANK; i++) begin
         if (found && (k_ext == SEL_W'(i + 1))) begin
            kth_value = list_ff[i];
         end
      end
   end

endmodule

FILE: rtl/kdms_datapath.sv
// ----------------------------------------------------------------------------
// kdms_datapath
// Datapath: the rank register, the two sorted lists and the result register.
// It acts only on commands from the controller, but for rank writes.
// ----------------------------------------------------------------------------
module kdms_datapath
   import kdms_pkg::*;
#(
   parameter int MAX_RANK = MAX_RANK_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   input  logic signed [VALUE_W-1:0]  value,
   input  logic                       csr_write,
   input  logic [RANK_W-1:0]          csr_data,
   output logic signed [VALUE_W-1:0]  kth_largest,
   output logic                       largest_found,
   output logic signed [VALUE_W-1:0]  kth_smallest,
   output logic                       smallest_found
);

   logic [RANK_W-1:0]         rank_ff;
   logic signed [VALUE_W-1:0] top_value;
   logic                      top_found;
   logic signed [VALUE_W-1:0] bot_value;
   logic                      bot_found;
   logic signed [VALUE_W-1:0] kth_largest_ff;
   logic                      largest_found_ff;
   logic signed [VALUE_W-1:0] kth_smallest_ff;
   logic                      smallest_found_ff;

   // Rank register, written from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= RANK_RESET;
      end else if (csr_write) begin
         rank_ff <= csr_data;
      end
   end

   // Largest distinct values, descending.
   kdms_list #(
      .MAX_RANK (MAX_RANK),
      .DESCEND  (1'b1)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .insert    (cmd.insert),
      .clear     (cmd.clear),
      .value     (value),
      .rank_k    (rank_ff),
      .kth_value (top_value),
      .found     (top_found)
   );

   // Smallest distinct values, ascending.
   kdms_list #(
      .MAX_RANK (MAX_RANK),
      .DESCEND  (1'b0)
   ) u_bottom (
      .clock     (clock),
      .reset     (reset),
      .insert    (cmd.insert),
      .clear     (cmd.clear),
      .value     (value),
      .rank_k    (rank_ff),
      .kth_value (bot_value),
      .found     (bot_found)
   );

   // Result register, loaded once per data set.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kth_largest_ff    <= top_value;
         largest_found_ff  <= top_found;
         kth_smallest_ff   <= bot_value;
         smallest_found_ff <= bot_found;
      end
   end

   assign kth_largest    = kth_largest_ff;
   assign largest_found  = largest_found_ff;
   assign kth_smallest   = kth_smallest_ff;
   assign smallest_found = smallest_found_ff;

endmodule

FILE: rtl/kdms_ctrl.sv
// ----------------------------------------------------------------------------
// kdms_ctrl
// Controller: takes items while running, and after the last item of a data
// set loads the result register and clears the lists once the result
// register is free.
// ----------------------------------------------------------------------------
module kdms_ctrl
   import kdms_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    req_last,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // State and result-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_RUN: begin
            req_ready  = 1'b1;
            cmd.insert = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            // Wait until the previous result has been taken.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load     = 1'b1;
               cmd.clear    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/kth_distinct_min_max_select_top.sv
// ----------------------------------------------------------------------------
// kth_distinct_min_max_select_top
// Reports the k-th largest and k-th smallest distinct value of a data set
// streamed one value per item, the final item marked by last.
//
//   Channel   Direction  Ports                                   Moves
//   req       in         req_valid/ready, req_value, req_last     one value
//   rsp       out        rsp_valid/ready, rsp_kth_*, rsp_*_found  one result
//   csr       in         csr_valid/ready, csr_rank_k              rank register
//
// Each item is inserted into both lists by the compare-insert row as it is
// taken. After a last item the block selects the rank into the result
// register and clears the lists, waiting while an earlier result is still
// held; no items are taken until that is done. Reset empties both lists,
// sets the rank to one and drops any pending result.
// ----------------------------------------------------------------------------
module kth_distinct_min_max_select_top
   import kdms_pkg::*;
#(
   parameter int MAX_RANK = MAX_RANK_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [VALUE_W-1:0]  rsp_kth_largest,
   output logic                       rsp_largest_found,
   output logic signed [VALUE_W-1:0]  rsp_kth_smallest,
   output logic                       rsp_smallest_found,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [RANK_W-1:0]          csr_rank_k
);

   cmd_type cmd;

   // The rank register takes a write in any cycle.
   assign csr_ready = 1'b1;

   // Controller.
   kdms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Datapath.
   kdms_datapath #(
      .MAX_RANK (MAX_RANK)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .value          (req_value),
      .csr_write      (csr_valid && csr_ready),
      .csr_data       (csr_rank_k),
      .kth_largest    (rsp_kth_largest),
      .largest_found  (rsp_largest_found),
      .kth_smallest   (rsp_kth_smallest),
      .smallest_found (rsp_smallest_found)
   );

endmodule

FILE: sim/tb_kth_distinct_min_max_select_top.sv
// ----------------------------------------------------------------------------
// tb_kth_distinct_min_max_select_top
// Self-checking bench for the k-th distinct largest and smallest selector.
// Data sets are streamed one value per item. A behavioural copy of the two
// sorted lists predicts each result, and every result the block gives is
// compared field by field with the oldest prediction. Directed sets cover the
// value extremes, duplicates, missing ranks and out-of-range ranks. A stall
// phase holds the result side off so that the block fills up and stalls its
// input; random phases then vary the rank, the set lengths and the idle gaps.
// ----------------------------------------------------------------------------
module tb_kth_distinct_min_max_select_top
   import kdms_pkg::*;
();

   localparam int DEPTH = MAX_RANK_DEF;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam int LIST_TOP    = 0;
   localparam int LIST_BOTTOM = 1;

   // One predicted result.
   typedef struct packed {
      logic signed [VALUE_W-1:0] largest;
      logic                      largest_found;
      logic signed [VALUE_W-1:0] smallest;
      logic                      smallest_found;
   } rank_pair_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      req_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_kth_largest;
   logic                      rsp_largest_found;
   logic signed [VALUE_W-1:0] rsp_kth_smallest;
   logic                      rsp_smallest_found;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [RANK_W-1:0]         csr_rank_k = RANK_RESET;

   // Predictor state: both sorted lists, their fill counts and the rank.
   logic signed [VALUE_W-1:0] sorted_vals [2][DEPTH];
   int                        sorted_fill [2];
   logic [RANK_W-1:0]         rank_now = RANK_RESET;

   rank_pair_type pending_ranks[$];
   int            mismatch_count = 0;
   int            random_items = 0;
   bit            no_idle = 1'b0;
   bit            hold_off_req = 1'b0;

   kth_distinct_min_max_select_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_value          (req_value),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kth_largest    (rsp_kth_largest),
      .rsp_largest_found  (rsp_largest_found),
      .rsp_kth_smallest   (rsp_kth_smallest),
      .rsp_smallest_found (rsp_smallest_found),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_rank_k         (csr_rank_k)
   );

   // Clock generation.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #8000000;
      $display("tb_kth_distinct_min_max_select_top: done, errors");
      $finish;
   end

   // Number of idle cycles before the next item on either side.
   function automatic int idle_draw();
      if (no_idle) return 0;
      return $urandom_range(0, 15);
   endfunction

   // Empty both predicted lists.
   function automatic void clear_lists();
      for (int i = 0; i < DEPTH; i++) begin
         sorted_vals[LIST_TOP][i]    = '0;
         sorted_vals[LIST_BOTTOM][i] = '0;
      end
      sorted_fill[LIST_TOP]    = 0;
      sorted_fill[LIST_BOTTOM] = 0;
   endfunction

   // Insert a value into one list of distinct values, keeping only the DEPTH
   // most extreme. The top list runs descending, the bottom list ascending.
   function automatic void insert_distinct(int id, logic signed [VALUE_W-1:0] v);
      int n;
      int p;
      int i;
      n = sorted_fill[id];
      p = 0;
      while (p < n && ((id == LIST_TOP) ? (sorted_vals[id][p] > v)
                                        : (sorted_vals[id][p] < v)))
         p++;
      if (p < n && sorted_vals[id][p] == v) return;
      if (p >= DEPTH) return;
      i = (n < DEPTH) ? n : DEPTH - 1;
      while (i > p) begin
         sorted_vals[id][i] = sorted_vals[id][i-1];
         i--;
      end
      sorted_vals[id][p] = v;
      if (n < DEPTH) sorted_fill[id] = n + 1;
   endfunction

   // Take one accepted item in; on the last item of a set, queue the
   // expected ranks and clear the lists.
   function automatic void absorb_value(logic signed [VALUE_W-1:0] v, logic is_last);
      rank_pair_type r;
      bit            rank_ok;
      insert_distinct(LIST_TOP, v);
      insert_distinct(LIST_BOTTOM, v);
      if (!is_last) return;
      rank_ok = (rank_now >= 1 && rank_now <= DEPTH);
      r = '0;
      if (rank_ok && rank_now <= sorted_fill[LIST_TOP]) begin
         r.largest       = sorted_vals[LIST_TOP][rank_now-1];
         r.largest_found = 1'b1;
      end
      if (rank_ok && rank_now <= sorted_fill[LIST_BOTTOM]) begin
         r.smallest       = sorted_vals[LIST_BOTTOM][rank_now-1];
         r.smallest_found = 1'b1;
      end
      pending_ranks.push_back(r);
      clear_lists();
   endfunction

   // Offer one item and wait until the block takes it.
   task automatic offer_value(input logic signed [VALUE_W-1:0] v, input logic is_last);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last  <= is_last;
      do @(posedge clock); while (!req_ready);
      absorb_value(v, is_last);
   endtask

   // Wait until every expected result has arrived and the block is idle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_ranks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the rank register; only called while the block is idle.
   task automatic write_rank(input logic [RANK_W-1:0] k);
      csr_valid  <= 1'b1;
      csr_rank_k <= k;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      rank_now = k;
   endtask

   // Draw one value: full range, a narrow band with many repeats, or extremes.
   function automatic logic signed [VALUE_W-1:0] pick_value(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 16)) - 8;
         default: begin
            case ($urandom_range(0, 4))
               0: return VAL_MIN;
               1: return VAL_MAX;
               2: return '0;
               3: return '1;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   // Extremes, duplicates, missing and out-of-range ranks.
   task automatic test_directed_cases();
      // Rank one straight after reset.
      offer_value(VAL_MAX, 1'b1);
      offer_value(VAL_MIN, 1'b0);
      offer_value(VAL_MAX, 1'b0);
      offer_value('1, 1'b0);
      offer_value('0, 1'b1);
      wait_drained();
      // Rank two: a set of repeats has one distinct value, so nothing is found.
      write_rank(5'd2);
      offer_value(32'sd5, 1'b0);
      offer_value(32'sd5, 1'b0);
      offer_value(32'sd5, 1'b1);
      offer_value(VAL_MIN, 1'b0);
      offer_value(VAL_MIN, 1'b0);
      offer_value(VAL_MAX, 1'b1);
      offer_value(32'sh5555_5555, 1'b0);
      offer_value(32'shAAAA_AAAA, 1'b0);
      offer_value(32'sh5555_5555, 1'b1);
      wait_drained();
      // Rank zero never finds anything.
      write_rank(5'd0);
      offer_value(32'sd3, 1'b0);
      offer_value(32'sd4, 1'b1);
      wait_drained();
      // Ranks beyond the list depth never find anything.
      write_rank(5'd31);
      offer_value(32'sd1, 1'b0);
      offer_value(32'sd2, 1'b1);
      wait_drained();
      write_rank(5'd17);
      offer_value(-32'sd1, 1'b1);
      wait_drained();
   endtask

   // The result side holds off while short sets arrive back to back, so the
   // block must stall its input.
   task automatic test_output_stall();
      int len;
      write_rank(5'd1);
      no_idle      = 1'b1;
      hold_off_req = 1'b1;
      for (int s = 0; s < 12; s++) begin
         len = $urandom_range(1, 3);
         for (int i = 0; i < len; i++)
            offer_value(pick_value(s % 3), i == len - 1);
      end
      wait_drained();
      no_idle = 1'b0;
   endtask

   // Random phases: a rank per phase, then several random sets.
   task automatic test_random_sets();
      int          len;
      int          mode;
      logic [4:0]  k;
      while (random_items < 1000) begin
         case ($urandom_range(0, 9))
            0:       k = 5'd0;
            1:       k = RANK_W'($urandom_range(17, 31));
            2:       k = 5'd16;
            default: k = RANK_W'($urandom_range(1, 16));
         endcase
         write_rank(k);
         no_idle = ($urandom_range(0, 4) == 0);
         repeat ($urandom_range(4, 10)) begin
            len  = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40)
                                               : $urandom_range(1, 12);
            mode = $urandom_range(0, 2);
            for (int i = 0; i < len; i++)
               offer_value(pick_value(mode), i == len - 1);
            random_items += len;
         end
         wait_drained();
      end
      no_idle = 1'b0;
   endtask

   // Result side: a random wait before each item, or a long hold-off on request.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            int w;
            w = idle_draw();
            if (w > 0) begin
               rsp_ready <= 1'b0;
               repeat (w) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid && !hold_off_req);
      end
   end

   // Report one field that differs from its prediction.
   function automatic void compare_field(string name, logic signed [VALUE_W-1:0] want,
                                         logic signed [VALUE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Check every accepted result against the oldest prediction.
   always @(posedge clock) begin : check_results
      rank_pair_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_ranks.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, actual %0d/%0d",
                     $time, rsp_kth_largest, rsp_kth_smallest);
            mismatch_count++;
         end else begin
            want = pending_ranks.pop_front();
            compare_field("kth_largest", want.largest, rsp_kth_largest);
            compare_field("largest_found", {31'b0, want.largest_found},
                          {31'b0, rsp_largest_found});
            compare_field("kth_smallest", want.smallest, rsp_kth_smallest);
            compare_field("smallest_found", {31'b0, want.smallest_found},
                          {31'b0, rsp_smallest_found});
         end
      end
   end

   // Test sequence.
   initial begin
      clear_lists();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_output_stall();
      test_random_sets();
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_ranks.size() == 0) begin
         $display("tb_kth_distinct_min_max_select_top: done, clean");
      end else begin
         $display("tb_kth_distinct_min_max_select_top: done, errors");
      end
      $finish;
   end

endmodule
